// ===== rtl/nsdf_kmp_pkg.sv =====
// Package for the NSDF key-maximum picker: field widths, frame limits and
// the constants of the divide-by-three used for the leading-skip bound.
// No dependencies.
package nsdf_kmp_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned PosW     = 12;
  localparam int unsigned LenW     = 13;
  localparam int unsigned MaxFrame = 4096;

  // floor(x / 3) = (x * Div3Mul) >> Div3Shift for every x below MaxFrame.
  localparam int unsigned Div3Mul   = 2731;
  localparam int unsigned Div3Shift = 13;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [PosW-1:0]           pos_t;
  typedef logic [LenW-1:0]           len_t;

endpackage

// ===== rtl/nsdf_key_maximum_picker_core.sv =====
// NSDF key-maximum picker: one correlation sample per item, picks the
// highest local maximum of each positive lobe and reports frame ends.
// Outputs are registered: a result is presented in the cycle after its sample's transfer.
// Throughput: one sample per cycle while the output is not stalled; the output register frees itself
// in the cycle its result is taken, so a stalled output holds one result.
// Reset clears the frame state and sets the frame length to MaxFrame.
module nsdf_key_maximum_picker_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  nsdf_kmp_pkg::sample_t     nsdf_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      peak_valid_o,
  output nsdf_kmp_pkg::pos_t        peak_position_o,
  output logic                      frame_done_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  nsdf_kmp_pkg::len_t        frame_length_i
);

  typedef enum logic [1:0] {
    PhSkipPos,
    PhSkipNonPos,
    PhLobe
  } phase_e;

  localparam nsdf_kmp_pkg::len_t MaxLen = nsdf_kmp_pkg::LenW'(nsdf_kmp_pkg::MaxFrame);
  localparam nsdf_kmp_pkg::pos_t MaxLenM1 = nsdf_kmp_pkg::PosW'(nsdf_kmp_pkg::MaxFrame - 1);
  localparam nsdf_kmp_pkg::pos_t MaxThird =
    nsdf_kmp_pkg::PosW'((nsdf_kmp_pkg::MaxFrame - 1) / 3);
  localparam int unsigned ProdW = nsdf_kmp_pkg::Div3Shift + nsdf_kmp_pkg::PosW;

  phase_e                 phase_q, phase_d;
  nsdf_kmp_pkg::pos_t     idx_q, idx_d;
  nsdf_kmp_pkg::sample_t  prev_q, prev_d;
  nsdf_kmp_pkg::sample_t  prev2_q, prev2_d;
  nsdf_kmp_pkg::pos_t     best_pos_q, best_pos_d;
  nsdf_kmp_pkg::sample_t  best_val_q, best_val_d;

  nsdf_kmp_pkg::pos_t     len_m1_q;
  nsdf_kmp_pkg::pos_t     third_q;
  nsdf_kmp_pkg::len_t     cfg_len;
  nsdf_kmp_pkg::pos_t     cfg_len_m1;
  logic [ProdW-1:0]       cfg_prod;

  logic                   out_valid_q;
  logic                   peak_valid_q, frame_done_q;
  nsdf_kmp_pkg::pos_t     peak_pos_q;

  logic                   in_fire;
  logic                   emit;
  logic                   res_valid, res_done;
  nsdf_kmp_pkg::pos_t     res_pos;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Clamp the written length to 1..MaxFrame and derive the leading-skip bound.
  always_comb begin
    cfg_len = frame_length_i;
    if (cfg_len == '0) begin
      cfg_len = nsdf_kmp_pkg::LenW'(1);
    end else if (cfg_len > MaxLen) begin
      cfg_len = MaxLen;
    end
    cfg_len_m1 = nsdf_kmp_pkg::PosW'(cfg_len - nsdf_kmp_pkg::LenW'(1));
    cfg_prod   = ProdW'(cfg_len_m1) * ProdW'(nsdf_kmp_pkg::Div3Mul);
  end

  always_comb begin
    logic   last;
    logic   x_pos;
    phase_e ph;

    last       = (idx_q >= len_m1_q);
    x_pos      = (nsdf_value_i > 0);
    ph         = phase_q;
    best_pos_d = best_pos_q;
    best_val_d = best_val_q;
    emit       = 1'b0;
    res_valid  = 1'b0;
    res_pos    = '0;
    res_done   = 1'b0;

    if (ph == PhSkipPos) begin
      if (!((idx_q < third_q) && x_pos)) begin
        ph = PhSkipNonPos;
      end
    end

    if (ph == PhSkipNonPos) begin
      if (x_pos && (idx_q != '0) && !last) begin
        ph = PhLobe;
      end
    end else if (ph == PhLobe) begin
      // The previous sample is judged now that its right neighbor is known.
      if ((prev_q > prev2_q) && (prev_q >= nsdf_value_i) &&
          ((best_pos_d == '0) || (prev_q > best_val_d))) begin
        best_pos_d = idx_q - nsdf_kmp_pkg::PosW'(1);
        best_val_d = prev_q;
      end
      if (!last && !x_pos) begin
        if (best_pos_d != '0) begin
          emit      = 1'b1;
          res_valid = 1'b1;
          res_pos   = best_pos_d;
        end
        best_pos_d = '0;
        best_val_d = '0;
        ph         = PhSkipNonPos;
      end
    end

    if (last) begin
      emit       = 1'b1;
      res_valid  = (best_pos_d != '0);
      res_pos    = best_pos_d;
      res_done   = 1'b1;
      phase_d    = PhSkipPos;
      idx_d      = '0;
      prev_d     = '0;
      prev2_d    = '0;
      best_pos_d = '0;
      best_val_d = '0;
    end else begin
      phase_d = ph;
      idx_d   = idx_q + nsdf_kmp_pkg::PosW'(1);
      prev_d  = nsdf_value_i;
      prev2_d = prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhSkipPos;
      idx_q      <= '0;
      prev_q     <= '0;
      prev2_q    <= '0;
      best_pos_q <= '0;
      best_val_q <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      prev_q     <= prev_d;
      prev2_q    <= prev2_d;
      best_pos_q <= best_pos_d;
      best_val_q <= best_val_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_m1_q <= MaxLenM1;
      third_q  <= MaxThird;
    end else if (cfg_valid_i) begin
      len_m1_q <= cfg_len_m1;
      third_q  <= cfg_prod[nsdf_kmp_pkg::Div3Shift +: nsdf_kmp_pkg::PosW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      peak_valid_q <= res_valid;
      peak_pos_q   <= res_pos;
      frame_done_q <= res_done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign peak_valid_o    = peak_valid_q;
  assign peak_position_o = peak_pos_q;
  assign frame_done_o    = frame_done_q;

endmodule
